### rtl/spatial_inertia_transform_defines.svh
// Assertion macros for the spatial inertia transform
`ifndef SPATIAL_INERTIA_TRANSFORM_DEFINES_SVH
`define SPATIAL_INERTIA_TRANSFORM_DEFINES_SVH

// check outside reset
`define SIT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check at every edge, reset included
`define SIT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/sit_pkg.sv
package sit_pkg;

   localparam int ACC_W = 66;
   localparam logic [2:0] LAST_ROW = 3'd5;
   localparam int ROT_SH = 30;
   localparam int FIX_SH = 16;

   localparam logic [2:0] CSR_IXX  = 3'd0;
   localparam logic [2:0] CSR_IYY  = 3'd1;
   localparam logic [2:0] CSR_IZZ  = 3'd2;
   localparam logic [2:0] CSR_IXY  = 3'd3;
   localparam logic [2:0] CSR_IXZ  = 3'd4;
   localparam logic [2:0] CSR_IYZ  = 3'd5;
   localparam logic [2:0] CSR_MASS = 3'd6;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7fff_ffff);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] prod_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   function automatic acc_type ext(input prod_type p);
      return {{(ACC_W-64){p[63]}}, p};
   endfunction

   function automatic acc_type rnd(input acc_type x, input int unsigned sh);
      acc_type half;
      half = '0;
      half[sh-1] = 1'b1;
      return (x + half) >>> sh;
   endfunction

   function automatic word_type sat32(input acc_type x);
      word_type r;
      if (x > SAT_HI) begin
         r = 32'sh7fff_ffff;
      end else if (x < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/sit_rows.sv
module sit_rows (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  sit_pkg::word_type     tl [3][3],
   input  sit_pkg::word_type     ms [3][3],
   input  logic [30:0]           mass,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_row_index,
   output logic signed [31:0]    rsp_col_0,
   output logic signed [31:0]    rsp_col_1,
   output logic signed [31:0]    rsp_col_2,
   output logic signed [31:0]    rsp_col_3,
   output logic signed [31:0]    rsp_col_4,
   output logic signed [31:0]    rsp_col_5,
   output logic                  rsp_last_row
);

   sit_pkg::word_type tl_ff [3][3];
   sit_pkg::word_type ms_ff [3][3];
   logic [30:0] mass_ff;
   logic        valid_ff, valid_in;
   logic [2:0]  row_ff, row_in;
   logic        last;
   logic [1:0]  k;
   sit_pkg::word_type mw;

   assign last       = (row_ff == sit_pkg::LAST_ROW);
   assign load_ready = !valid_ff || (rsp_ready && last);
   assign rsp_valid  = valid_ff;
   assign rsp_row_index = row_ff;
   assign rsp_last_row  = last;
   assign mw = {1'b0, mass_ff};

   always_comb begin
      valid_in = valid_ff;
      row_in   = row_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
         row_in   = 3'd0;
      end else if (valid_ff && rsp_ready) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            row_in = row_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         tl_ff   <= tl;
         ms_ff   <= ms;
         mass_ff <= mass;
      end
   end

   always_comb begin
      if (row_ff < 3'd3) begin
         k = row_ff[1:0];
         rsp_col_0 = tl_ff[k][0];
         rsp_col_1 = tl_ff[k][1];
         rsp_col_2 = tl_ff[k][2];
         rsp_col_3 = ms_ff[k][0];
         rsp_col_4 = ms_ff[k][1];
         rsp_col_5 = ms_ff[k][2];
      end else begin
         k = 2'(row_ff - 3'd3);
         rsp_col_0 = ms_ff[0][k];
         rsp_col_1 = ms_ff[1][k];
         rsp_col_2 = ms_ff[2][k];
         rsp_col_3 = (k == 2'd0) ? mw : '0;
         rsp_col_4 = (k == 2'd1) ? mw : '0;
         rsp_col_5 = (k == 2'd2) ? mw : '0;
      end
   end

endmodule

### rtl/spatial_inertia_transform.sv
// Spatial inertia transform.
// Request channel (req_*): a rotation R (Q2.30, row-major) and a translation
// (Q16.16), taken on req_valid && req_ready. Configuration (csr_*): body
// inertia and mass, written with csr_write_enable; write only while idle.
// Response channel (rsp_*): six rows of the 6x6 spatial inertia, rows 0..5,
// rsp_last_row on row 5, one row per accepted cycle.
// Row 0 shows once its accepted request has passed the stage 1, 2 and 3
// registers and stage 4 has rounded it into the row buffer.
// A new request loads the row buffer as the previous last row is taken, at
// one row per accepted cycle; requests queue in the pipeline behind it.
// Reset: clears all valid bits and the configuration to zero.
// Stall: with rsp_ready low the current row holds, the pipeline fills, then
// req_ready drops; nothing is lost or repeated.
module spatial_inertia_transform (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_rot_00,
   input  logic signed [31:0] req_rot_01,
   input  logic signed [31:0] req_rot_02,
   input  logic signed [31:0] req_rot_10,
   input  logic signed [31:0] req_rot_11,
   input  logic signed [31:0] req_rot_12,
   input  logic signed [31:0] req_rot_20,
   input  logic signed [31:0] req_rot_21,
   input  logic signed [31:0] req_rot_22,
   input  logic signed [31:0] req_shift_x,
   input  logic signed [31:0] req_shift_y,
   input  logic signed [31:0] req_shift_z,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_row_index,
   output logic signed [31:0] rsp_col_0,
   output logic signed [31:0] rsp_col_1,
   output logic signed [31:0] rsp_col_2,
   output logic signed [31:0] rsp_col_3,
   output logic signed [31:0] rsp_col_4,
   output logic signed [31:0] rsp_col_5,
   output logic               rsp_last_row
);

   sit_pkg::word_type ixx_ff, iyy_ff, izz_ff, ixy_ff, ixz_ff, iyz_ff;
   logic [30:0] mass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ixx_ff  <= '0;
         iyy_ff  <= '0;
         izz_ff  <= '0;
         ixy_ff  <= '0;
         ixz_ff  <= '0;
         iyz_ff  <= '0;
         mass_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            sit_pkg::CSR_IXX:  ixx_ff  <= csr_write_data;
            sit_pkg::CSR_IYY:  iyy_ff  <= csr_write_data;
            sit_pkg::CSR_IZZ:  izz_ff  <= csr_write_data;
            sit_pkg::CSR_IXY:  ixy_ff  <= csr_write_data;
            sit_pkg::CSR_IXZ:  ixz_ff  <= csr_write_data;
            sit_pkg::CSR_IYZ:  iyz_ff  <= csr_write_data;
            sit_pkg::CSR_MASS: mass_ff <= csr_write_data[30:0];
            default: begin
            end
         endcase
      end
   end

   logic v1_ff, v2_ff, v3_ff;
   logic e1, e2, e3, ob_ready;

   assign e3 = !v3_ff || ob_ready;
   assign e2 = !v2_ff || e3;
   assign e1 = !v1_ff || e2;
   assign req_ready = e1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (e1) v1_ff <= req_valid;
         if (e2) v2_ff <= v1_ff;
         if (e3) v3_ff <= v2_ff;
      end
   end

   // stage 1: R*I and translation products
   sit_pkg::word_type rot [3][3];
   sit_pkg::word_type icol [3][3];
   sit_pkg::word_type mw;
   sit_pkg::prod_type pri_in [3][3][3];
   sit_pkg::prod_type ptt_in [6];
   sit_pkg::prod_type pmt_in [3];
   sit_pkg::prod_type pri_ff [3][3][3];
   sit_pkg::prod_type ptt_ff [6];
   sit_pkg::prod_type pmt_ff [3];
   sit_pkg::word_type rot1_ff [3][3];
   logic [30:0] m1_ff;

   assign mw = {1'b0, mass_ff};

   always_comb begin
      rot[0][0] = req_rot_00; rot[0][1] = req_rot_01; rot[0][2] = req_rot_02;
      rot[1][0] = req_rot_10; rot[1][1] = req_rot_11; rot[1][2] = req_rot_12;
      rot[2][0] = req_rot_20; rot[2][1] = req_rot_21; rot[2][2] = req_rot_22;
      icol[0][0] = ixx_ff; icol[0][1] = ixy_ff; icol[0][2] = ixz_ff;
      icol[1][0] = ixy_ff; icol[1][1] = iyy_ff; icol[1][2] = iyz_ff;
      icol[2][0] = ixz_ff; icol[2][1] = iyz_ff; icol[2][2] = izz_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               pri_in[i][j][k] = rot[i][k] * icol[k][j];
            end
         end
      end
      ptt_in[0] = req_shift_x * req_shift_x;
      ptt_in[1] = req_shift_y * req_shift_y;
      ptt_in[2] = req_shift_z * req_shift_z;
      ptt_in[3] = req_shift_x * req_shift_y;
      ptt_in[4] = req_shift_x * req_shift_z;
      ptt_in[5] = req_shift_y * req_shift_z;
      pmt_in[0] = mw * req_shift_x;
      pmt_in[1] = mw * req_shift_y;
      pmt_in[2] = mw * req_shift_z;
   end

   always_ff @(posedge clock) begin
      if (e1) begin
         pri_ff  <= pri_in;
         ptt_ff  <= ptt_in;
         pmt_ff  <= pmt_in;
         rot1_ff <= rot;
         m1_ff   <= mass_ff;
      end
   end

   // stage 2: round T, G and m*S
   sit_pkg::word_type t_in [3][3];
   sit_pkg::word_type g_in [3][3];
   sit_pkg::word_type ms_in [3][3];
   sit_pkg::word_type mp [3];
   sit_pkg::word_type mn [3];
   sit_pkg::word_type t2_ff [3][3];
   sit_pkg::word_type g2_ff [3][3];
   sit_pkg::word_type ms2_ff [3][3];
   sit_pkg::word_type rot2_ff [3][3];
   logic [30:0] m2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            t_in[i][j] = sit_pkg::sat32(sit_pkg::rnd(sit_pkg::ext(pri_ff[i][j][0])
               + sit_pkg::ext(pri_ff[i][j][1]) + sit_pkg::ext(pri_ff[i][j][2]),
               sit_pkg::ROT_SH));
         end
      end
      g_in[0][0] = sit_pkg::sat32(sit_pkg::rnd(sit_pkg::ext(ptt_ff[1])
         + sit_pkg::ext(ptt_ff[2]), sit_pkg::FIX_SH));
      g_in[1][1] = sit_pkg::sat32(sit_pkg::rnd(sit_pkg::ext(ptt_ff[0])
         + sit_pkg::ext(ptt_ff[2]), sit_pkg::FIX_SH));
      g_in[2][2] = sit_pkg::sat32(sit_pkg::rnd(sit_pkg::ext(ptt_ff[0])
         + sit_pkg::ext(ptt_ff[1]), sit_pkg::FIX_SH));
      g_in[0][1] = sit_pkg::sat32(sit_pkg::rnd(-sit_pkg::ext(ptt_ff[3]), sit_pkg::FIX_SH));
      g_in[0][2] = sit_pkg::sat32(sit_pkg::rnd(-sit_pkg::ext(ptt_ff[4]), sit_pkg::FIX_SH));
      g_in[1][2] = sit_pkg::sat32(sit_pkg::rnd(-sit_pkg::ext(ptt_ff[5]), sit_pkg::FIX_SH));
      g_in[1][0] = g_in[0][1];
      g_in[2][0] = g_in[0][2];
      g_in[2][1] = g_in[1][2];
      for (int c = 0; c < 3; c++) begin
         mp[c] = sit_pkg::sat32(sit_pkg::rnd(sit_pkg::ext(pmt_ff[c]), sit_pkg::FIX_SH));
         mn[c] = sit_pkg::sat32(sit_pkg::rnd(-sit_pkg::ext(pmt_ff[c]), sit_pkg::FIX_SH));
      end
      ms_in[0][0] = '0;    ms_in[0][1] = mn[2]; ms_in[0][2] = mp[1];
      ms_in[1][0] = mp[2]; ms_in[1][1] = '0;    ms_in[1][2] = mn[0];
      ms_in[2][0] = mn[1]; ms_in[2][1] = mp[0]; ms_in[2][2] = '0;
   end

   always_ff @(posedge clock) begin
      if (e2) begin
         t2_ff   <= t_in;
         g2_ff   <= g_in;
         ms2_ff  <= ms_in;
         rot2_ff <= rot1_ff;
         m2_ff   <= m1_ff;
      end
   end

   // stage 3: T*R^T and m*G products
   sit_pkg::prod_type pa_in [3][3][3];
   sit_pkg::prod_type pmg_in [3][3];
   sit_pkg::prod_type pa_ff [3][3][3];
   sit_pkg::prod_type pmg_ff [3][3];
   sit_pkg::word_type ms3_ff [3][3];
   sit_pkg::word_type m2w;
   logic [30:0] m3_ff;

   assign m2w = {1'b0, m2_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               pa_in[i][j][k] = t2_ff[i][k] * rot2_ff[j][k];
            end
            pmg_in[i][j] = m2w * g2_ff[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e3) begin
         pa_ff  <= pa_in;
         pmg_ff <= pmg_in;
         ms3_ff <= ms2_ff;
         m3_ff  <= m2_ff;
      end
   end

   // stage 4: round and sum into the row buffer
   sit_pkg::word_type tl [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tl[i][j] = sit_pkg::sat32(
               sit_pkg::rnd(sit_pkg::ext(pa_ff[i][j][0]) + sit_pkg::ext(pa_ff[i][j][1])
                  + sit_pkg::ext(pa_ff[i][j][2]), sit_pkg::ROT_SH)
               + sit_pkg::rnd(sit_pkg::ext(pmg_ff[i][j]), sit_pkg::FIX_SH));
         end
      end
   end

   sit_rows u_rows (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (v3_ff),
      .load_ready    (ob_ready),
      .tl            (tl),
      .ms            (ms3_ff),
      .mass          (m3_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_col_0     (rsp_col_0),
      .rsp_col_1     (rsp_col_1),
      .rsp_col_2     (rsp_col_2),
      .rsp_col_3     (rsp_col_3),
      .rsp_col_4     (rsp_col_4),
      .rsp_col_5     (rsp_col_5),
      .rsp_last_row  (rsp_last_row)
   );

endmodule

### rtl/sit_checker.sv
`include "spatial_inertia_transform_defines.svh"

module sit_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_row_index,
   input logic signed [31:0] rsp_col_0,
   input logic               rsp_last_row
);

   `SIT_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "response valid after reset")
   `SIT_ASSERT(a_last_flag, rsp_valid |-> (rsp_last_row == (rsp_row_index == sit_pkg::LAST_ROW)), "last_row mismatch")
   `SIT_ASSERT(a_row_range, rsp_valid |-> (rsp_row_index <= sit_pkg::LAST_ROW), "row index out of range")
   `SIT_ASSERT(a_row_next, (rsp_valid && rsp_ready && !rsp_last_row) |=> (rsp_valid && rsp_row_index == $past(rsp_row_index) + 3'd1), "rows not back to back")
   `SIT_ASSERT(a_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_col_0)), "stalled row changed")

endmodule

bind spatial_inertia_transform sit_checker u_sit_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_row_index (rsp_row_index),
   .rsp_col_0     (rsp_col_0),
   .rsp_last_row  (rsp_last_row)
);
